// ===== sv/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types, constants and the lead byte length lookup for the utf-8 decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] LEN_TABLE  = 64'h4322_0000_1111_1111;
   localparam logic [7:0]  CONT_MASK  = 8'hC0;
   localparam logic [7:0]  CONT_CODE  = 8'h80;
   localparam logic [7:0]  LEAD_LIMIT = 8'hF7;
   localparam logic [7:0]  MASK_CONT  = 8'h3F;
   localparam logic [7:0]  MASK_LEAD2 = 8'h1F;
   localparam logic [7:0]  MASK_LEAD3 = 8'h0F;
   localparam logic [7:0]  MASK_LEAD4 = 8'h07;

   localparam logic [2:0] LEN_STRAY = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [20:0] code_point;
      logic        is_error;
      logic [2:0]  seq_length;
      logic        last;
   } result_type;

   // one queue entry: the results caused by one byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   function automatic logic [2:0] lead_len(input logic [3:0] nib);
      logic [63:0] sh;
      sh = LEN_TABLE >> {nib, 2'b00};
      return sh[2:0];
   endfunction

endpackage

// ===== sv/u8d_front.sv =====
// ----------------------------------------------------------------------------
// u8d_front
// takes one byte per transfer, updates the sequence state and builds the
// results that the byte causes
// ----------------------------------------------------------------------------
module u8d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               q_full,
   output logic               q_push,
   output u8d_pkg::entry_type q_entry
);

   logic [1:0]  rem_ff,  rem_in;
   logic [20:0] pv_ff,   pv_in;
   logic [2:0]  tlen_ff, tlen_in;
   logic        skip_ff, skip_in;

   logic                accept;
   logic                is_cont;
   logic [7:0]          b;
   logic [2:0]          n;
   logic                lead_res;
   u8d_pkg::result_type lead_r;
   logic [1:0]          lead_rem;
   logic [20:0]         lead_pv;
   logic [2:0]          lead_tlen;
   logic                lead_skip;
   logic [20:0]         pv_shift;
   logic [1:0]          count;
   u8d_pkg::entry_type  ent;

   assign b         = req_data_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_cont   = (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE;
   assign n         = u8d_pkg::lead_len(b[7:4]);
   assign pv_shift  = {pv_ff[14:0], b[5:0]};

   // lead byte handling from a cleared sequence state
   always_comb begin
      lead_res  = 1'b0;
      lead_r    = '0;
      lead_rem  = 2'd0;
      lead_pv   = '0;
      lead_tlen = u8d_pkg::LEN_STRAY;
      lead_skip = 1'b0;
      unique case (n)
         u8d_pkg::LEN_ONE: begin
            lead_res          = 1'b1;
            lead_r.code_point = {13'd0, b};
            lead_r.seq_length = u8d_pkg::LEN_ONE;
         end
         u8d_pkg::LEN_TWO: begin
            lead_rem  = 2'd1;
            lead_pv   = {13'd0, b & u8d_pkg::MASK_LEAD2};
            lead_tlen = u8d_pkg::LEN_TWO;
         end
         u8d_pkg::LEN_THREE: begin
            lead_rem  = 2'd2;
            lead_pv   = {13'd0, b & u8d_pkg::MASK_LEAD3};
            lead_tlen = u8d_pkg::LEN_THREE;
         end
         u8d_pkg::LEN_FOUR: begin
            if (b > u8d_pkg::LEAD_LIMIT) begin
               lead_res        = 1'b1;
               lead_r.is_error = 1'b1;
            end else begin
               lead_rem  = 2'd3;
               lead_pv   = {13'd0, b & u8d_pkg::MASK_LEAD4};
               lead_tlen = u8d_pkg::LEN_FOUR;
            end
         end
         default: begin
            lead_res        = 1'b1;
            lead_r.is_error = 1'b1;
            lead_skip       = 1'b1;
         end
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      pv_in   = pv_ff;
      tlen_in = tlen_ff;
      skip_in = skip_ff;
      count   = 2'd0;
      ent     = '0;
      if (rem_ff != 2'd0) begin
         if (is_cont) begin
            rem_in = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               count                = 2'd1;
               ent.r0.code_point    = pv_shift;
               ent.r0.seq_length    = tlen_ff;
               ent.r0.last          = 1'b1;
               pv_in                = '0;
               tlen_in              = u8d_pkg::LEN_STRAY;
            end else begin
               pv_in = pv_shift;
            end
         end else begin
            // truncated sequence: error first, then the byte as a new lead
            ent.r0.is_error = 1'b1;
            ent.r0.last     = !lead_res;
            ent.r1          = lead_r;
            ent.r1.last     = 1'b1;
            ent.two         = lead_res;
            count           = lead_res ? 2'd2 : 2'd1;
            rem_in          = lead_rem;
            pv_in           = lead_pv;
            tlen_in         = lead_tlen;
            skip_in         = lead_skip;
         end
      end else if (skip_ff && is_cont) begin
         count = 2'd0;
      end else begin
         ent.r0      = lead_r;
         ent.r0.last = 1'b1;
         count       = lead_res ? 2'd1 : 2'd0;
         rem_in      = lead_rem;
         pv_in       = lead_pv;
         tlen_in     = lead_tlen;
         skip_in     = lead_skip;
      end
   end

   assign q_push  = accept && (count != 2'd0);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         pv_ff   <= '0;
         tlen_ff <= '0;
         skip_ff <= 1'b0;
      end else if (accept) begin
         rem_ff  <= rem_in;
         pv_ff   <= pv_in;
         tlen_ff <= tlen_in;
         skip_ff <= skip_in;
      end
   end

   a_len_covers_rem: assert property (@(posedge clock) disable iff (reset)
      (rem_ff != 2'd0) |-> (tlen_ff > {1'b0, rem_ff}))
      else $error("sequence length below remaining count");

   a_no_skip_in_seq: assert property (@(posedge clock) disable iff (reset)
      (rem_ff != 2'd0) |-> !skip_ff)
      else $error("skipping while a sequence is open");

endmodule

// ===== sv/u8d_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_queue
// short first-in first-out queue of result entries between front and back
// ----------------------------------------------------------------------------
module u8d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8d_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output u8d_pkg::entry_type head
);

   u8d_pkg::entry_type        mem_ff [u8d_pkg::QUEUE_DEPTH];
   logic [u8d_pkg::QUEUE_AW:0] wr_ff, wr_in;
   logic [u8d_pkg::QUEUE_AW:0] rd_ff, rd_in;

   assign full = (wr_ff[u8d_pkg::QUEUE_AW] != rd_ff[u8d_pkg::QUEUE_AW]) &&
                 (wr_ff[u8d_pkg::QUEUE_AW-1:0] == rd_ff[u8d_pkg::QUEUE_AW-1:0]);
   assign not_empty = wr_ff != rd_ff;
   assign head      = mem_ff[rd_ff[u8d_pkg::QUEUE_AW-1:0]];
   assign wr_in     = wr_ff + 1'b1;
   assign rd_in     = rd_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff[u8d_pkg::QUEUE_AW-1:0]] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

// ===== sv/u8d_back.sv =====
// ----------------------------------------------------------------------------
// u8d_back
// output register: takes entries from the queue and sends their results one
// transfer at a time
// ----------------------------------------------------------------------------
module u8d_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  u8d_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [20:0]        rsp_code_point,
   output logic               rsp_is_error,
   output logic [2:0]         rsp_seq_length,
   output logic               rsp_last
);

   u8d_pkg::entry_type  hold_ff;
   logic                valid_ff;
   logic                phase_ff;
   logic                take;
   logic                done;
   u8d_pkg::result_type cur;

   assign cur   = phase_ff ? hold_ff.r1 : hold_ff.r0;
   assign take  = valid_ff && rsp_ready;
   assign done  = take && (phase_ff || !hold_ff.two);
   assign q_pop = q_not_empty && (!valid_ff || done);

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = cur.code_point;
   assign rsp_is_error   = cur.is_error;
   assign rsp_seq_length = cur.seq_length;
   assign rsp_last       = cur.last;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         hold_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
         phase_ff <= 1'b0;
      end else if (done) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= 1'b1;
      end
   end

   a_phase_needs_two: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (valid_ff && hold_ff.two))
      else $error("second result selected for a single entry");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !phase_ff && hold_ff.two) |-> !rsp_last)
      else $error("first of two results marked last");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_is_error) |-> (rsp_code_point == '0 && rsp_seq_length == '0))
      else $error("error result with payload");

endmodule

// ===== sv/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial utf-8 decoder with a front classifier, a four-entry queue and
// a result output register
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the four-entry queue has room; decoding
// of a byte, including its effect on the open sequence, completes in the cycle
// it is taken. A byte causes zero, one or two results, and the output register
// sends one result per cycle while the receiver is ready, so a byte with two
// results (a cut-short sequence followed by an ascii byte or a lead above f7)
// holds the output until both are sent. A result passes the queue and then
// the output register before it is offered; input stalls only when the queue fills.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_error,
   output logic [2:0]  rsp_seq_length,
   output logic        rsp_last
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_not_empty;
   u8d_pkg::entry_type q_entry;
   u8d_pkg::entry_type q_head;

   u8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   u8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_is_error   (rsp_is_error),
      .rsp_seq_length (rsp_seq_length),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte-serial utf-8 decoder: a byte queue feeds a
// valid/ready driver, each accepted byte is decoded by a local predictor, and a
// monitor compares every result transfer field by field with the oldest
// predicted result, under random idling on both sides, a long receiver
// hold-off and a full drain pause
// ----------------------------------------------------------------------------
module tb;

   localparam int DIRECTED_BYTES = 25;
   localparam int RANDOM_BYTES   = 400;
   localparam int TAIL_ITEMS     = 40;
   localparam int DRAIN_AT       = 250;
   localparam int HOLD_AT        = 100;
   localparam int HOLD_CYCLES    = 120;
   localparam int SETTLE_CYCLES  = 20;
   localparam int STUCK_LIMIT    = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_is_error;
   logic [2:0]  rsp_seq_length;
   logic        rsp_last;

   logic [7:0]          stream_bytes[$];
   u8d_pkg::result_type pending_chars[$];

   // predictor state
   logic [1:0]  conts_needed = '0;
   logic [20:0] gathered_bits = '0;
   logic [2:0]  open_length = '0;
   logic        swallowing = 1'b0;

   int stream_total = 0;
   int bytes_taken = 0;
   int results_checked = 0;
   int errors_seen = 0;
   int twin_bytes = 0;
   int fails = 0;
   int send_gap = 0, send_calm = 0, recv_stall = 0, recv_calm = 0;
   int hold_left = 0;
   int stuck_cycles = 0;
   bit drain_done = 1'b0;
   bit hold_done = 1'b0;
   bit tail_quiet = 1'b0;

   utf8_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_is_error   (rsp_is_error),
      .rsp_seq_length (rsp_seq_length),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void decode_byte(input logic [7:0] b);
      u8d_pkg::result_type chars[2];
      u8d_pkg::result_type bad;
      int                  n;
      logic                is_cont;
      logic                as_lead;
      n       = 0;
      as_lead = 1'b0;
      is_cont = (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE;
      bad     = '{code_point: '0, is_error: 1'b1,
                  seq_length: u8d_pkg::LEN_STRAY, last: 1'b0};
      if (conts_needed != 0) begin
         if (is_cont) begin
            gathered_bits = {gathered_bits[14:0], b[5:0]};
            conts_needed  = conts_needed - 2'd1;
            if (conts_needed == 0) begin
               chars[0] = '{code_point: gathered_bits, is_error: 1'b0,
                            seq_length: open_length, last: 1'b0};
               n = 1;
               gathered_bits = '0;
               open_length   = '0;
            end
         end else begin
            chars[0]      = bad;
            n             = 1;
            conts_needed  = '0;
            gathered_bits = '0;
            open_length   = '0;
            as_lead       = 1'b1;
         end
      end else if (swallowing) begin
         if (!is_cont) begin
            swallowing = 1'b0;
            as_lead    = 1'b1;
         end
      end else begin
         as_lead = 1'b1;
      end
      if (as_lead) begin
         case (b[7:4])
            4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: begin
               chars[n] = '{code_point: {13'd0, b}, is_error: 1'b0,
                            seq_length: u8d_pkg::LEN_ONE, last: 1'b0};
               n++;
            end
            4'hC, 4'hD: begin
               gathered_bits = {13'd0, b & u8d_pkg::MASK_LEAD2};
               conts_needed  = 2'd1;
               open_length   = u8d_pkg::LEN_TWO;
            end
            4'hE: begin
               gathered_bits = {13'd0, b & u8d_pkg::MASK_LEAD3};
               conts_needed  = 2'd2;
               open_length   = u8d_pkg::LEN_THREE;
            end
            4'hF: begin
               if (b > u8d_pkg::LEAD_LIMIT) begin
                  chars[n] = bad;
                  n++;
               end else begin
                  gathered_bits = {13'd0, b & u8d_pkg::MASK_LEAD4};
                  conts_needed  = 2'd3;
                  open_length   = u8d_pkg::LEN_FOUR;
               end
            end
            default: begin
               swallowing = 1'b1;
               chars[n]   = bad;
               n++;
            end
         endcase
      end
      if (n > 0) chars[n-1].last = 1'b1;
      if (n == 2) twin_bytes++;
      for (int i = 0; i < n; i++) pending_chars.push_back(chars[i]);
   endfunction

   // driver
   always @(posedge clock) begin : drive
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte);
            bytes_taken++;
         end
         tail_quiet <= stream_bytes.size() < TAIL_ITEMS;
         if (req_valid && !req_ready) begin
            // offer held until transfer
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!drain_done && bytes_taken == DRAIN_AT) begin
            req_valid <= 1'b0;
            if (pending_chars.size() == 0) drain_done = 1'b1;
         end else if (stream_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!tail_quiet && send_calm == 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 15) - 1;
            if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(20, 80);
            req_valid <= 1'b0;
         end else begin
            if (send_calm > 0) send_calm--;
            req_valid     <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
         end
      end
   end

   // receiver side ready
   always @(posedge clock) begin : receive
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_checked >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (!tail_quiet && recv_calm == 0 && $urandom_range(0, 4) == 0) begin
         recv_stall = $urandom_range(1, 15) - 1;
         if ($urandom_range(0, 2) == 0) recv_calm = $urandom_range(20, 80);
         rsp_ready <= 1'b0;
      end else begin
         if (recv_calm > 0) recv_calm--;
         rsp_ready <= 1'b1;
      end
   end

   // check the transfer that the coming rising edge will make
   always @(negedge clock) begin : check
      u8d_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected result: code_point %h is_error %b seq_length %0d last %b",
                   rsp_code_point, rsp_is_error, rsp_seq_length, rsp_last);
            fails++;
         end else begin
            want = pending_chars.pop_front();
            results_checked++;
            if (want.is_error) errors_seen++;
            if (rsp_code_point !== want.code_point) begin
               $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
               fails++;
            end
            if (rsp_is_error !== want.is_error) begin
               $error("is_error: expected %b, got %b", want.is_error, rsp_is_error);
               fails++;
            end
            if (rsp_seq_length !== want.seq_length) begin
               $error("seq_length: expected %0d, got %0d", want.seq_length, rsp_seq_length);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("utf8_stream_decoder regression: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int kind;
      int len;
      int cnt;
      // ascii extremes, each sequence length, largest code point, leads above f7,
      // stray run then swallowing, cut-short sequences, overlong two-byte zero
      stream_bytes = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF8, 8'hFF,
                       8'h80, 8'hBF, 8'h41, 8'hC3, 8'h41, 8'hE2, 8'hC3, 8'hA9,
                       8'hF0, 8'hF8, 8'hC0, 8'h80};
      while (stream_bytes.size() < DIRECTED_BYTES + RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            stream_bytes.push_back({1'b0, 7'($urandom)});
         end else if (kind < 85) begin
            len = kind < 55 ? 2 : (kind < 70 ? 3 : 4);
            case (len)
               2: stream_bytes.push_back({3'b110, 5'($urandom)});
               3: stream_bytes.push_back({4'b1110, 4'($urandom)});
               default: stream_bytes.push_back({5'b11110, 3'($urandom)});
            endcase
            for (int i = 1; i < len; i++) stream_bytes.push_back({2'b10, 6'($urandom)});
         end else if (kind < 90) begin
            stream_bytes.push_back(8'($urandom));
         end else if (kind < 94) begin
            len = $urandom_range(2, 4);
            case (len)
               2: stream_bytes.push_back({3'b110, 5'($urandom)});
               3: stream_bytes.push_back({4'b1110, 4'($urandom)});
               default: stream_bytes.push_back({5'b11110, 3'($urandom)});
            endcase
            cnt = $urandom_range(0, len - 2);
            for (int i = 0; i < cnt; i++) stream_bytes.push_back({2'b10, 6'($urandom)});
         end else if (kind < 97) begin
            cnt = $urandom_range(1, 4);
            for (int i = 0; i < cnt; i++) stream_bytes.push_back({2'b10, 6'($urandom)});
         end else begin
            stream_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         end
      end
      stream_total = stream_bytes.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (bytes_taken < stream_total || pending_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d bytes and %0d results, %0d of them errors,", bytes_taken,
               results_checked, errors_seen);
      $display("with %0d bytes giving two results each", twin_bytes);
      if (fails == 0) begin
         $display("utf8_stream_decoder regression: pass");
      end else begin
         $display("utf8_stream_decoder regression: fail");
      end
      $finish;
   end

endmodule
